### rtl/core/sctinterp_pkg.sv
// Shared types and constants for the sorted curve table interpolator.
// Depends on nothing.
package sctinterp_pkg;

	localparam int SPEED_W = 20;
	localparam int VAL_W   = 24;
	localparam int OP_W    = 2;
	localparam int IDX_W   = 2;
	localparam int MIN_VALID_POINTS = 3;
	localparam logic [VAL_W-1:0] SPREAD_FLOOR = VAL_W'(16);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_ISCAN  = 10'b0000000010,
		ST_ISHIFT = 10'b0000000100,
		ST_LSCAN  = 10'b0000001000,
		ST_LRD    = 10'b0000010000,
		ST_LMUL   = 10'b0000100000,
		ST_LDIV   = 10'b0001000000,
		ST_LADD   = 10'b0010000000,
		ST_OUT    = 10'b0100000000,
		ST_RDWAIT = 10'b1000000000
	} state_t;

endpackage

### rtl/core/sorted_curve_table_interpolator.sv
// Sorted curve table interpolator: top level.
// Uses sctinterp_pkg; holds the point memory, a sequencer and a serial divider.
//
// Usage:
//  s_axis carries one request per item: opcode, curve index, speed, mean, spread.
//  m_axis returns one result per request: success, mean, spread.
//  A request is taken only when the block is idle (s_axis_tready high); it stays
//  low until the result has been taken. Steps:
//   clear       : sets the curve's point count to zero
//   insert      : scans for the slot, then shifts the later points up (fails on a full curve)
//   lookup      : scans up to the first point above the speed, then one multiply and
//                 divide pass for the mean and one for the spread, then the output state
//  The scan and shift go through the single read port of the point memory;
//  the 44-step radix-2 divider computes both interpolations in turn.
//  Reset clears all point counts; the point memory is not cleared, since
//  slots at or above a curve's count are never used.
//  When the receiver stalls, the result holds on m_axis and no request is taken.
module sorted_curve_table_interpolator
	import sctinterp_pkg::*;
#(
	parameter int POINTS_PER_CURVE = 16,
	parameter int CURVES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// opcode[1:0], curve_index[3:2], speed[23:4], period_mean_in[47:24],
	// period_spread_in[71:48]
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// success[0], period_mean_out[24:1], period_spread_out[48:25], zeros above
	output logic [55:0] m_axis_tdata
);

	localparam int PW = $clog2(POINTS_PER_CURVE);
	localparam int CW = (CURVES > 1) ? $clog2(CURVES) : 1;
	localparam int NW = $clog2(POINTS_PER_CURVE + 1);
	localparam int DEPTH = CURVES * POINTS_PER_CURVE;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MW = SPEED_W + VAL_W;
	localparam int ENT_W = SPEED_W + 2 * VAL_W;

	logic [ENT_W-1:0] mem [DEPTH];
	logic [ENT_W-1:0] rd_q;
	logic [NW-1:0]    cnt_q [CURVES];

	state_t state_q, ret_q;
	logic [CW-1:0]      cur_q;
	logic [SPEED_W-1:0] spd_q;
	logic [VAL_W-1:0]   mean_q, sprd_q;
	logic [NW-1:0]      n_q, k_q;
	logic               ok_q, half_q;
	logic [ENT_W-1:0]   lo_q;
	logic [SPEED_W-1:0] num_q, den_q;
	logic               neg_q;
	logic [MW-1:0]      rem_q, quo_q;
	logic [5:0]         bit_q;
	logic [VAL_W-1:0]   res_mean_q, res_sprd_q;
	logic               out_v_q;

	logic               we;
	logic [AW-1:0]      waddr, raddr;
	logic [ENT_W-1:0]   wdata;
	logic [IDX_W-1:0]   in_cur;
	logic               cur_ok;

	assign in_cur = s_axis_tdata[3:2];
	assign cur_ok = {30'd0, in_cur} < CURVES;
	assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'd0, res_sprd_q, res_mean_q, ok_q};

	function automatic logic [AW-1:0] addr(logic [CW-1:0] c, logic [NW-1:0] k);
		return AW'(c * POINTS_PER_CURVE + k);
	endfunction

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// fields of read entry
	logic [SPEED_W-1:0] rd_s;
	logic [VAL_W-1:0]   rd_m, rd_d, lo_m, lo_d, lo_v, hi_v, diff;
	assign rd_s = rd_q[SPEED_W-1:0];
	assign rd_m = rd_q[SPEED_W +: VAL_W];
	assign rd_d = rd_q[SPEED_W+VAL_W +: VAL_W];
	assign lo_m = lo_q[SPEED_W +: VAL_W];
	assign lo_d = lo_q[SPEED_W+VAL_W +: VAL_W];
	assign lo_v = half_q ? lo_d : lo_m;
	assign hi_v = half_q ? rd_d : rd_m;
	assign diff = (hi_v >= lo_v) ? hi_v - lo_v : lo_v - hi_v;

	logic [MW:0] rem_sh;
	assign rem_sh = {rem_q, quo_q[MW-1]};

	always_comb begin
		we = 1'b0;
		waddr = addr(cur_q, k_q);
		wdata = {sprd_q, mean_q, spd_q};
		raddr = addr(cur_q, k_q);
		case (state_q)
			ST_ISHIFT: begin
				if (k_q == lo_q[NW-1:0] || half_q) begin
					we = 1'b1;
				end
				if (half_q) begin
					wdata = rd_q;
				end
				raddr = addr(cur_q, k_q - NW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			out_v_q <= 1'b0;
			for (int i = 0; i < CURVES; i++) begin
				cnt_q[i] <= '0;
			end
			ok_q <= 1'b0;
			res_mean_q <= '0;
			res_sprd_q <= '0;
			half_q <= 1'b0;
		end else begin
			if (out_v_q && m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						cur_q  <= CW'(in_cur);
						spd_q  <= s_axis_tdata[23:4];
						mean_q <= s_axis_tdata[47:24];
						sprd_q <= s_axis_tdata[71:48];
						n_q    <= cnt_q[CW'(in_cur)];
						k_q    <= '0;
						half_q <= 1'b0;
						ok_q   <= 1'b0;
						res_mean_q <= '0;
						res_sprd_q <= '0;
						if (!cur_ok) begin
							state_q <= ST_OUT;
						end else begin
							case (s_axis_tdata[1:0])
								OP_CLEAR: begin
									cnt_q[CW'(in_cur)] <= '0;
									ok_q <= 1'b1;
									state_q <= ST_OUT;
								end
								OP_INSERT: begin
									if (cnt_q[CW'(in_cur)] >= NW'(POINTS_PER_CURVE)) begin
										state_q <= ST_OUT;
									end else begin
										state_q <= ST_RDWAIT;
										ret_q <= ST_ISCAN;
									end
								end
								OP_LOOKUP: begin
									if (cnt_q[CW'(in_cur)] < NW'(MIN_VALID_POINTS)) begin
										state_q <= ST_OUT;
									end else begin
										state_q <= ST_RDWAIT;
										ret_q <= ST_LSCAN;
									end
								end
								default: state_q <= ST_OUT;
							endcase
						end
					end
				end
				ST_RDWAIT: state_q <= ret_q;
				ST_ISCAN: begin
					// rd_q holds entry k_q
					if (k_q == n_q || spd_q < rd_s) begin
						// insert at k_q: shift from n down to k_q
						lo_q[NW-1:0] <= k_q;
						k_q <= n_q;
						half_q <= 1'b0;
						state_q <= ST_ISHIFT;
						if (k_q != n_q) begin
							// entry k_q is known to move; handled by shift loop
						end
					end else begin
						k_q <= k_q + NW'(1);
						state_q <= ST_RDWAIT;
						ret_q <= ST_ISCAN;
					end
				end
				ST_ISHIFT: begin
					// pos in lo_q[NW-1:0]; half_q=0: read k-1 issued; 1: write k <- rd_q
					if (k_q == lo_q[NW-1:0]) begin
						cnt_q[cur_q] <= n_q + NW'(1);
						ok_q <= 1'b1;
						state_q <= ST_OUT;
						half_q <= 1'b0;
					end else if (!half_q) begin
						half_q <= 1'b1;
					end else begin
						half_q <= 1'b0;
						k_q <= k_q - NW'(1);
					end
				end
				ST_LSCAN: begin
					if (k_q == '0 && spd_q < rd_s) begin
						state_q <= ST_OUT;
					end else if (k_q != '0 && spd_q < rd_s) begin
						// bracket found: lo_q holds entry k-1, rd_q entry k
						num_q <= spd_q - lo_q[SPEED_W-1:0];
						den_q <= rd_s - lo_q[SPEED_W-1:0];
						half_q <= 1'b0;
						state_q <= ST_LMUL;
					end else if (k_q == n_q - NW'(1)) begin
						ok_q <= 1'b1;
						res_mean_q <= rd_m;
						res_sprd_q <= rd_d;
						state_q <= ST_OUT;
					end else begin
						lo_q <= rd_q;
						k_q <= k_q + NW'(1);
						state_q <= ST_RDWAIT;
						ret_q <= ST_LSCAN;
					end
				end
				ST_LMUL: begin
					quo_q  <= MW'(num_q * diff);
					rem_q  <= '0;
					neg_q  <= hi_v < lo_v;
					bit_q  <= 6'(MW);
					state_q <= ST_LDIV;
				end
				ST_LDIV: begin
					if (rem_sh >= {{(MW-SPEED_W+1){1'b0}}, den_q}) begin
						rem_q <= MW'(rem_sh - {{(MW-SPEED_W+1){1'b0}}, den_q});
						quo_q <= {quo_q[MW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[MW-1:0];
						quo_q <= {quo_q[MW-2:0], 1'b0};
					end
					bit_q <= bit_q - 6'd1;
					if (bit_q == 6'd1) begin
						state_q <= ST_LADD;
					end
				end
				ST_LADD: begin
					if (!half_q) begin
						res_mean_q <= neg_q ? lo_v - quo_q[VAL_W-1:0] : lo_v + quo_q[VAL_W-1:0];
						half_q <= 1'b1;
						state_q <= ST_LMUL;
					end else begin
						if ((neg_q ? lo_v - quo_q[VAL_W-1:0] : lo_v + quo_q[VAL_W-1:0])
							< SPREAD_FLOOR) begin
							res_sprd_q <= SPREAD_FLOOR;
						end else begin
							res_sprd_q <= neg_q ? lo_v - quo_q[VAL_W-1:0]
								: lo_v + quo_q[VAL_W-1:0];
						end
						ok_q <= 1'b1;
						half_q <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/sctinterp_checker.sv
// Port-level checks for the sorted curve table interpolator.
// Depends on sctinterp_pkg; bound to the top level.
module sctinterp_checker
	import sctinterp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("request taken with result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[48:1] == '0)
		else $error("failed result carries data");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[55:49] == '0) else $error("pad bits set");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after request");

endmodule

bind sorted_curve_table_interpolator sctinterp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));

### tb/sv/sorted_curve_table_interpolator_tb.sv
// Testbench for the sorted curve table interpolator: directed table, then random requests,
// with results checked against a behavioral curve table kept in the bench.
// Depends on sctinterp_pkg and the sorted_curve_table_interpolator RTL.
`timescale 1ns / 100ps

module sorted_curve_table_interpolator_tb;
	import sctinterp_pkg::*;

	localparam int NPTS = 16;
	localparam int NCRV = 4;
	localparam int IDLE_LIMIT = 5000;

	typedef struct packed {
		logic [VAL_W-1:0]   spread;
		logic [VAL_W-1:0]   mean;
		logic [SPEED_W-1:0] speed;
		logic [IDX_W-1:0]   curve;
		op_t                op;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] spread;
		logic [VAL_W-1:0] mean;
		logic             ok;
	} res_t;

	typedef struct {
		req_t req;
		bit   has_res;
		res_t res;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [55:0] m_axis_tdata;

	int          send_idle = 35, recv_idle = 66;
	int          mismatches = 0;
	int          idle_cycles = 0;
	res_t        expected_q[$];
	row_t        rows[$];

	int          cnt[NCRV];
	logic [SPEED_W-1:0] tab_s[NCRV][NPTS];
	logic [VAL_W-1:0]   tab_m[NCRV][NPTS];
	logic [VAL_W-1:0]   tab_d[NCRV][NPTS];

	sorted_curve_table_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic logic [VAL_W-1:0] lerp(logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi,
			longint unsigned num, longint unsigned den);
		longint unsigned mag;
		if (hi >= lo) begin
			mag = (num * longint'(hi - lo)) / den;
			return lo + VAL_W'(mag);
		end
		mag = (num * longint'(lo - hi)) / den;
		return lo - VAL_W'(mag);
	endfunction

	function automatic res_t curve_apply(req_t r);
		res_t o;
		int   c, n, pos;
		logic [VAL_W-1:0] dd;
		o = '0;
		c = r.curve;
		n = cnt[c];
		case (r.op)
			OP_CLEAR: begin
				cnt[c] = 0;
				o.ok = 1'b1;
			end
			OP_INSERT: begin
				if (n < NPTS) begin
					pos = n;
					for (int k = n - 1; k >= 0; k--)
						if (r.speed < tab_s[c][k]) pos = k;
					for (int k = n; k > pos; k--) begin
						tab_s[c][k] = tab_s[c][k-1];
						tab_m[c][k] = tab_m[c][k-1];
						tab_d[c][k] = tab_d[c][k-1];
					end
					tab_s[c][pos] = r.speed;
					tab_m[c][pos] = r.mean;
					tab_d[c][pos] = r.spread;
					cnt[c] = n + 1;
					o.ok = 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (n >= MIN_VALID_POINTS && r.speed >= tab_s[c][0]) begin
					if (r.speed >= tab_s[c][n-1]) begin
						o.ok = 1'b1;
						o.mean = tab_m[c][n-1];
						o.spread = tab_d[c][n-1];
					end else begin
						for (int k = 0; k + 1 < n; k++)
							if (!o.ok && r.speed >= tab_s[c][k] && r.speed < tab_s[c][k+1]) begin
								o.ok = 1'b1;
								o.mean = lerp(tab_m[c][k], tab_m[c][k+1],
									r.speed - tab_s[c][k], tab_s[c][k+1] - tab_s[c][k]);
								dd = lerp(tab_d[c][k], tab_d[c][k+1],
									r.speed - tab_s[c][k], tab_s[c][k+1] - tab_s[c][k]);
								o.spread = (dd < SPREAD_FLOOR) ? SPREAD_FLOOR : dd;
							end
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic send(req_t r);
		res_t e;
		@(posedge clk);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		s_axis_tdata <= 72'(r);
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
		s_axis_tvalid <= 0;
		e = curve_apply(r);
		expected_q.push_back(e);
	endtask

	always @(posedge clk) begin
		if (arst_n)
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		res_t got, e;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[48:0];
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				e = expected_q.pop_front();
				if (got !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp ok=%0d m=%h d=%h got ok=%0d m=%h d=%h",
							e.ok, e.mean, e.spread, got.ok, got.mean, got.spread);
				end
			end
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic req_t mk(op_t op, int c, logic [SPEED_W-1:0] s,
			logic [VAL_W-1:0] m, logic [VAL_W-1:0] d);
		req_t r;
		r.op = op; r.curve = IDX_W'(c); r.speed = s; r.mean = m; r.spread = d;
		return r;
	endfunction

	task automatic add_row(req_t r, bit has, res_t e);
		row_t w;
		w.req = r; w.has_res = has; w.res = e;
		rows.push_back(w);
	endtask

	function automatic req_t rand_req();
		req_t r;
		int   p;
		p = $urandom_range(99);
		r.curve = IDX_W'($urandom_range(3));
		r.mean = VAL_W'($urandom);
		r.spread = ($urandom_range(3) == 0) ? VAL_W'($urandom_range(40)) : VAL_W'($urandom);
		r.speed = ($urandom_range(3) == 0) ? SPEED_W'($urandom) : SPEED_W'($urandom_range(4000));
		if (p < 4) r.op = OP_CLEAR;
		else if (p < 6) r.op = OP_NONE;
		else if (p < 45) r.op = OP_INSERT;
		else r.op = OP_LOOKUP;
		return r;
	endfunction

	initial begin
		res_t z;
		res_t got_pred;
		int   guard;
		z = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		add_row(mk(OP_LOOKUP, 0, 0, 0, 0), 1, z);
		add_row(mk(OP_INSERT, 0, 100, 1000, 5), 1, '{spread: 0, mean: 0, ok: 1});
		add_row(mk(OP_INSERT, 0, 200, 500, 5), 1, '{spread: 0, mean: 0, ok: 1});
		add_row(mk(OP_LOOKUP, 0, 150, 0, 0), 1, z);
		add_row(mk(OP_INSERT, 0, 200, 24'hFFFFFF, 24'hFFFFFF), 1, '{spread: 0, mean: 0, ok: 1});
		add_row(mk(OP_LOOKUP, 0, 99, 0, 0), 1, z);
		add_row(mk(OP_LOOKUP, 0, 100, 0, 0), 0, z);
		add_row(mk(OP_LOOKUP, 0, 150, 0, 0), 0, z);
		add_row(mk(OP_LOOKUP, 0, 200, 0, 0), 1, '{spread: 24'hFFFFFF, mean: 24'hFFFFFF, ok: 1});
		add_row(mk(OP_LOOKUP, 0, 20'hFFFFF, 0, 0), 1,
			'{spread: 24'hFFFFFF, mean: 24'hFFFFFF, ok: 1});
		add_row(mk(OP_INSERT, 0, 0, 0, 0), 0, z);
		add_row(mk(OP_LOOKUP, 0, 50, 0, 0), 0, z);
		add_row(mk(OP_NONE, 0, 20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF), 1, z);
		for (int k = 0; k < 17; k++)
			add_row(mk(OP_INSERT, 3, SPEED_W'(20'hFFFFF - k * 7), VAL_W'($urandom),
				VAL_W'($urandom)), 0, z);
		add_row(mk(OP_LOOKUP, 3, 20'hFFFF0, 0, 0), 0, z);
		add_row(mk(OP_CLEAR, 3, 0, 0, 0), 1, '{spread: 0, mean: 0, ok: 1});
		add_row(mk(OP_LOOKUP, 3, 20'hFFFFF, 0, 0), 1, z);
		add_row(mk(OP_CLEAR, 0, 0, 0, 0), 1, '{spread: 0, mean: 0, ok: 1});

		foreach (rows[i]) begin
			got_pred = curve_apply(rows[i].req);
			// predictor must agree with the typed-in rows; the DUT is checked via the queue
			if (rows[i].has_res && got_pred !== rows[i].res) begin
				mismatches++;
				if (mismatches <= 10) $display("directed row %0d table entry disagrees", i);
			end
		end
		for (int c = 0; c < NCRV; c++) cnt[c] = 0;
		foreach (rows[i]) send(rows[i].req);

		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin send_idle = 66; recv_idle = 35; end
			if (ph == 2) begin send_idle = 0; recv_idle = 0; end
			repeat (370) send(rand_req());
		end

		guard = 0;
		while (expected_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

### sorted_curve_table_interpolator.f
rtl/core/sctinterp_pkg.sv
rtl/core/sorted_curve_table_interpolator.sv
rtl/core/sctinterp_checker.sv
tb/sv/sorted_curve_table_interpolator_tb.sv
